/* rtl/core/ewtp_pkg.sv */
// Shared types and constants for the energy-weighted task priority core.
// Used by the top, front, divider, back and checker modules; depends on nothing else.
package ewtp_pkg;

  localparam logic [1:0] FUNC_ENQUEUE   = 2'd0;
  localparam logic [1:0] FUNC_RUN_START = 2'd1;
  localparam logic [1:0] FUNC_RUN_STOP  = 2'd2;
  localparam logic [1:0] FUNC_EXIT      = 2'd3;

  localparam logic [13:0] ENERGY_SCALE = 14'd10000;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS = 64;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY_GLOBAL,
    OP_KEY,
    OP_START,
    OP_STOP,
    OP_EXIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] slot;
    logic [5:0]  cpu;
    logic [63:0] now;
    logic [63:0] energy;
    logic [63:0] vrt;
  } req_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } back_stat_t;

endpackage

/* rtl/core/energy_weighted_task_priority_core.sv */
// Top level of the energy-weighted task priority core.
// Depends on ewtp_pkg, ewtp_front and ewtp_back.
//
// A request is taken at a rising edge where start is high and busy is low.
// Run start, run stop and task exit update the tables and give no result.
// An enqueue gives one result: out_valid is high for exactly one cycle with
// out_to_global_queue and out_priority_key, and the receiver cannot stall it.
// Results come out in request order.
// A short queue of two requests sits in front of the sequencer, so busy only
// rises when that queue is full or while tables are cleared.
// Kernel-thread enqueue, start, exit and ignored events pass only through the
// sequencer's read and execute states; an enqueue and a run stop also use the
// one-bit-per-cycle 64-step divider that both share, an enqueue once unless its
// task power is zero and a run stop up to twice. After reset, busy stays high
// while the per-task and per-processor tables are cleared one entry a cycle.
module energy_weighted_task_priority_core
  import ewtp_pkg::*;
#(
  parameter int NUM_TASKS = 4096,
  parameter int NUM_CPUS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_task_slot,
  input  logic [5:0]  in_cpu_index,
  input  logic        in_kernel_thread,
  input  logic [63:0] in_now_ns,
  input  logic [63:0] in_energy_reading,
  input  logic [63:0] in_virtual_runtime,
  output logic        out_valid,
  output logic        out_to_global_queue,
  output logic [63:0] out_priority_key
);

  back_stat_t stat;
  logic       head_valid;
  req_t       head;

  ewtp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_task_slot      (in_task_slot),
    .in_cpu_index      (in_cpu_index),
    .in_kernel_thread  (in_kernel_thread),
    .in_now_ns         (in_now_ns),
    .in_energy_reading (in_energy_reading),
    .in_virtual_runtime(in_virtual_runtime),
    .stat              (stat),
    .head_valid        (head_valid),
    .head              (head)
  );

  ewtp_back #(
    .NUM_TASKS(NUM_TASKS),
    .NUM_CPUS (NUM_CPUS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head               (head),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_to_global_queue(out_to_global_queue),
    .out_priority_key   (out_priority_key)
  );

endmodule

/* rtl/core/ewtp_front.sv */
// Front part: accepts requests, classifies them and queues them for the back part.
// Depends on ewtp_pkg.
module ewtp_front
  import ewtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_task_slot,
  input  logic [5:0]  in_cpu_index,
  input  logic        in_kernel_thread,
  input  logic [63:0] in_now_ns,
  input  logic [63:0] in_energy_reading,
  input  logic [63:0] in_virtual_runtime,
  input  back_stat_t  stat,
  output logic        head_valid,
  output req_t        head
);

  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  req_t            q_r [QUEUE_DEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;
  op_t             op;
  req_t            req;
  logic            push, pop;

  always_comb begin
    case (in_func)
      FUNC_ENQUEUE:   op = in_kernel_thread ? OP_KEY_GLOBAL : OP_KEY;
      FUNC_RUN_START: op = in_kernel_thread ? OP_NONE : OP_START;
      FUNC_RUN_STOP:  op = in_kernel_thread ? OP_NONE : OP_STOP;
      FUNC_EXIT:      op = OP_EXIT;
      default:        op = OP_NONE;
    endcase
  end

  assign req = '{op: op, slot: in_task_slot, cpu: in_cpu_index, now: in_now_ns,
                 energy: in_energy_reading, vrt: in_virtual_runtime};

  assign busy       = (cnt_r == CNTW'(QUEUE_DEPTH)) || stat.clearing;
  assign push       = start && !busy;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];
  assign pop        = head_valid && stat.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wp_r] <= req;
        wp_r <= (wp_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ewtp_div.sv */
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
// Depends on ewtp_pkg.
module ewtp_div
  import ewtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem_r, quo_r, den_r;
  logic [6:0]  cnt_r;
  logic        run_r, done_r;
  logic [64:0] trial, diff;
  logic        qbit;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = !diff[64];
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
        cnt_r <= 7'(DIV_STEPS);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= qbit ? diff[63:0] : trial[63:0];
        quo_r <= {quo_r[62:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/ewtp_back.sv */
// Back part: per-task and per-processor tables, energy accounting and key sequencer.
// Depends on ewtp_pkg and ewtp_div.
module ewtp_back
  import ewtp_pkg::*;
#(
  parameter int NUM_TASKS = 4096,
  parameter int NUM_CPUS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  req_t        head,
  output back_stat_t  stat,
  output logic        out_valid,
  output logic        out_to_global_queue,
  output logic [63:0] out_priority_key
);

  localparam int TAW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CAW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CLR_N = (NUM_TASKS > NUM_CPUS) ? NUM_TASKS : NUM_CPUS;
  localparam int CLW   = $clog2(CLR_N + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DE, S_WAIT_INST, S_SYS, S_WAIT_SYS,
    S_WAIT_KEY, S_M0, S_M1, S_M2
  } state_t;

  state_t state_r;
  logic [CLW-1:0] clr_cnt_r;
  req_t        cur_r;
  logic        out_valid_r, out_gq_r, div_go_r;
  logic [63:0] out_key_r, sys_power_r, tt_r, te_r;
  logic [63:0] dt_r, diff_r, de_r, div_n_r, div_d_r, mul_b_r, acc_r;

  logic [64:0] row_mem [NUM_TASKS];
  logic [63:0] st_mem [NUM_TASKS];
  logic [64:0] base_mem [NUM_CPUS];
  logic [64:0] row_q, base_q;
  logic [63:0] st_q;

  logic           row_we, st_we, base_we;
  logic [TAW-1:0] row_wa, task_a;
  logic [CAW-1:0] base_wa, cpu_a;
  logic [64:0]    row_wd, base_wd;

  logic        slot_ok, cpu_ok, div_done;
  logic [63:0] div_quo, pw, dt_raw, dt_c, power_new;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  ewtp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go_r),
    .num  (div_n_r),
    .den  (div_d_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign task_a    = TAW'(cur_r.slot);
  assign cpu_a     = CAW'(cur_r.cpu);
  assign slot_ok   = 32'(cur_r.slot) < NUM_TASKS;
  assign cpu_ok    = 32'(cur_r.cpu) < NUM_CPUS;
  assign pw        = slot_ok ? row_q[63:0] : 64'd0;
  assign dt_raw    = cur_r.now - st_q;
  assign dt_c      = (dt_raw == 64'd0) ? 64'd1 : dt_raw;
  assign power_new = (row_q[63:0] >> 1) + (div_quo >> 1);

  assign stat.ready    = (state_r == S_IDLE);
  assign stat.clearing = (state_r == S_CLEAR);

  assign out_valid           = out_valid_r;
  assign out_to_global_queue = out_gq_r;
  assign out_priority_key    = out_key_r;

  always_comb begin
    case (state_r)
      S_M0: begin
        ma = cur_r.vrt[31:0];
        mb = mul_b_r[31:0];
      end
      S_M1: begin
        ma = cur_r.vrt[31:0];
        mb = mul_b_r[63:32];
      end
      default: begin
        ma = cur_r.vrt[63:32];
        mb = mul_b_r[31:0];
      end
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    row_we  = 1'b0;
    row_wa  = task_a;
    row_wd  = '0;
    st_we   = 1'b0;
    base_we = 1'b0;
    base_wa = cpu_a;
    base_wd = {1'b1, cur_r.energy};
    case (state_r)
      S_CLEAR: begin
        row_we  = 32'(clr_cnt_r) < NUM_TASKS;
        row_wa  = TAW'(clr_cnt_r);
        base_we = 32'(clr_cnt_r) < NUM_CPUS;
        base_wa = CAW'(clr_cnt_r);
        base_wd = '0;
      end
      S_EXEC: begin
        case (cur_r.op)
          OP_START: begin
            row_we  = slot_ok;
            row_wd  = {1'b1, row_q[63:0]};
            st_we   = slot_ok;
            base_we = cpu_ok;
          end
          OP_EXIT: begin
            row_we = slot_ok;
            row_wd = {row_q[64], 64'd0};
          end
          OP_STOP: begin
            base_we = slot_ok && row_q[64] && cpu_ok && !base_q[64];
          end
          default: begin
          end
        endcase
      end
      S_WAIT_INST: begin
        row_we  = div_done;
        row_wd  = {1'b1, power_new};
        base_we = div_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (st_we) begin
      st_mem[task_a] <= cur_r.now;
    end
    if (base_we) begin
      base_mem[base_wa] <= base_wd;
    end
    row_q  <= row_mem[task_a];
    st_q   <= st_mem[task_a];
    base_q <= base_mem[cpu_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      sys_power_r <= 64'd1;
      tt_r        <= '0;
      te_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLW'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            cur_r   <= head;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          case (cur_r.op)
            OP_KEY_GLOBAL: begin
              out_valid_r <= 1'b1;
              out_gq_r    <= 1'b1;
              out_key_r   <= '0;
            end
            OP_KEY: begin
              if (pw == 64'd0) begin
                mul_b_r <= 64'd1;
                state_r <= S_M0;
              end else begin
                div_n_r  <= pw;
                div_d_r  <= sys_power_r;
                div_go_r <= 1'b1;
                state_r  <= S_WAIT_KEY;
              end
            end
            OP_STOP: begin
              if (slot_ok && row_q[64] && cpu_ok && base_q[64] &&
                  base_q[63:0] != cur_r.energy) begin
                dt_r    <= dt_c;
                diff_r  <= cur_r.energy - base_q[63:0];
                state_r <= S_DE;
              end
            end
            default: begin
            end
          endcase
        end
        S_DE: begin
          de_r     <= 64'(diff_r * ENERGY_SCALE);
          div_n_r  <= 64'(diff_r * ENERGY_SCALE);
          div_d_r  <= dt_r;
          div_go_r <= 1'b1;
          state_r  <= S_WAIT_INST;
        end
        S_WAIT_INST: begin
          if (div_done) begin
            tt_r    <= tt_r + dt_r;
            te_r    <= te_r + de_r;
            state_r <= S_SYS;
          end
        end
        S_SYS: begin
          if (tt_r == 64'd0) begin
            sys_power_r <= 64'd1;
            state_r     <= S_IDLE;
          end else begin
            div_n_r  <= te_r;
            div_d_r  <= tt_r;
            div_go_r <= 1'b1;
            state_r  <= S_WAIT_SYS;
          end
        end
        S_WAIT_SYS: begin
          if (div_done) begin
            sys_power_r <= (div_quo == 64'd0) ? 64'd1 : div_quo;
            state_r     <= S_IDLE;
          end
        end
        S_WAIT_KEY: begin
          if (div_done) begin
            mul_b_r <= div_quo;
            state_r <= S_M0;
          end
        end
        S_M0: begin
          acc_r   <= prod;
          state_r <= S_M1;
        end
        S_M1: begin
          acc_r   <= acc_r + {prod[31:0], 32'd0};
          state_r <= S_M2;
        end
        S_M2: begin
          out_valid_r <= 1'b1;
          out_gq_r    <= 1'b0;
          out_key_r   <= acc_r + {prod[31:0], 32'd0};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ewtp_checker.sv */
// Port-level checks for the energy-weighted task priority core, bound to the top level.
// Depends on ewtp_pkg and energy_weighted_task_priority_core.
module ewtp_checker
  import ewtp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_to_global_queue,
  input logic [63:0] out_priority_key
);

  a_global_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_to_global_queue) |-> (out_priority_key == 64'd0))
    else $error("Global queue result carries a nonzero key.");

  a_single_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Results arrived in consecutive cycles.");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result strobe seen right after reset.");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("Request accepted while tables are being cleared.");

endmodule

bind energy_weighted_task_priority_core ewtp_checker u_ewtp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_to_global_queue(out_to_global_queue),
  .out_priority_key   (out_priority_key)
);
